// ----- rtl/log2_latency_histogram_percentile_defines.svh -----
// Assertion macros used by the checker of the latency histogram.
`ifndef LOG2_LATENCY_HISTOGRAM_PERCENTILE_DEFINES_SVH
`define LOG2_LATENCY_HISTOGRAM_PERCENTILE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LLHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LLHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/llhp_pkg.sv -----
// ----------------------------------------------------------------------------
// llhp_pkg
// Types and fixed constants of the log2 latency histogram with percentile
// lookup: item structs, request codes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package llhp_pkg;

    localparam int CNT_W    = 32;
    localparam int RATIO_W  = 20;
    localparam int LEN_W    = 6;
    localparam int PROD_W   = CNT_W + RATIO_W;

    localparam logic [RATIO_W-1:0] PPM_ONE = 20'd1000000;

    typedef enum logic [1:0] {
        REQ_RECORD = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_code_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [CNT_W-1:0]   latency_us;
        logic [RATIO_W-1:0] ratio_ppm;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0] percentile_us;
        logic [CNT_W-1:0] sample_count;
        logic [CNT_W-1:0] max_latency_us;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic rec_rd;
        logic clear;
        logic rec_wr;
        logic q_mul;
        logic walk_rd;
        logic walk_acc;
        logic walk_cmp;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic walk_hit;
        logic walk_last;
    } status_t;

endpackage

// ----- rtl/llhp_ram.sv -----
// ----------------------------------------------------------------------------
// llhp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module llhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/llhp_ctrl.sv -----
// ----------------------------------------------------------------------------
// llhp_ctrl
// Controller of the latency histogram: sequences record, query and clear
// items through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
module llhp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_type,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  llhp_pkg::status_t status,
    output llhp_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC_WR,
        ST_Q_MUL,
        ST_Q_RD,
        ST_Q_ACC,
        ST_Q_CMP,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (req_type)
                        llhp_pkg::REQ_RECORD:
                        begin
                            cmd.rec_rd = 1'b1;
                            state_next = ST_REC_WR;
                        end
                        llhp_pkg::REQ_QUERY:
                        begin
                            state_next = ST_Q_MUL;
                        end
                        llhp_pkg::REQ_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_REC_WR:
            begin
                cmd.rec_wr = 1'b1;
                state_next = ST_EMIT;
            end
            ST_Q_MUL:
            begin
                // An empty histogram answers zero, which accept already set.
                if (status.empty)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.q_mul  = 1'b1;
                    state_next = ST_Q_RD;
                end
            end
            ST_Q_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = ST_Q_ACC;
            end
            ST_Q_ACC:
            begin
                cmd.walk_acc = 1'b1;
                state_next   = ST_Q_CMP;
            end
            ST_Q_CMP:
            begin
                cmd.walk_cmp = 1'b1;
                if (status.walk_hit || status.walk_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_Q_RD;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- rtl/llhp_dp.sv -----
// ----------------------------------------------------------------------------
// llhp_dp
// Datapath of the latency histogram: bucket RAM with valid bits, sample count
// and maximum, target product and the scaled cumulative walk.
// ----------------------------------------------------------------------------
module llhp_dp #(
    parameter int NUM_BUCKETS  = 33,
    parameter int LATENCY_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  llhp_pkg::cmd_t    cmd,
    input  llhp_pkg::req_t    req_data,
    output llhp_pkg::status_t status,
    output llhp_pkg::rsp_t    rsp_data
);

    localparam int CNT_W     = llhp_pkg::CNT_W;
    localparam int BIDX_W    = $clog2(NUM_BUCKETS);
    localparam int CW        = (BIDX_W > llhp_pkg::LEN_W) ? BIDX_W : llhp_pkg::LEN_W;
    localparam int ACC_W     = CNT_W + BIDX_W;
    localparam int SCL_W     = ACC_W + llhp_pkg::RATIO_W;
    localparam int PROD_W    = llhp_pkg::PROD_W;
    localparam int MASK_BITS = (LATENCY_BITS < CNT_W) ? LATENCY_BITS : CNT_W;
    localparam logic [CNT_W-1:0] LAT_MASK =
        (MASK_BITS >= CNT_W) ? {CNT_W{1'b1}} : CNT_W'((64'd1 << MASK_BITS) - 64'd1);
    localparam logic [CW-1:0]     LAST_IDX = CW'(NUM_BUCKETS - 1);
    localparam logic [BIDX_W-1:0] LAST_B   = BIDX_W'(NUM_BUCKETS - 1);

    // Bucket selection for a record item.
    logic [CNT_W-1:0]          sample;
    logic [llhp_pkg::LEN_W-1:0] bit_len;
    logic [CW-1:0]             bidx_ext;
    logic [BIDX_W-1:0]         bidx;

    // Bucket store.
    logic [NUM_BUCKETS-1:0] valid_reg;
    logic                   rd_valid_reg;
    logic                   ram_re;
    logic [BIDX_W-1:0]      ram_raddr;
    logic [CNT_W-1:0]       ram_q;
    logic [CNT_W-1:0]       bucket_val;
    logic [CNT_W-1:0]       bucket_inc;

    // Running statistics and the item under work.
    logic [CNT_W-1:0]             total_reg;
    logic [CNT_W-1:0]             max_reg;
    logic [CNT_W-1:0]             sample_reg;
    logic [BIDX_W-1:0]            bidx_reg;
    logic [llhp_pkg::RATIO_W-1:0] ratio_reg;
    logic [CNT_W-1:0]             pct_reg;
    llhp_pkg::rsp_t               rsp_reg;

    // Cumulative walk.
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] scl_inc_reg;
    logic [SCL_W-1:0]  scaled_reg;
    logic [SCL_W-1:0]  scaled_next;
    logic [BIDX_W-1:0] idx_reg;
    logic [ACC_W-1:0]  accum_reg;
    logic [CW-1:0]     idx_ext;
    logic [CNT_W-1:0]  bound;
    logic [CNT_W-1:0]  hit_pct;
    logic              hit;

    assign sample = req_data.latency_us & LAT_MASK;

    always_comb
    begin
        bit_len = '0;
        for (int k = 0; k < CNT_W; k++)
        begin
            if (sample[k])
            begin
                bit_len = llhp_pkg::LEN_W'(k + 1);
            end
        end
    end

    assign bidx_ext = (CW'(bit_len) > LAST_IDX) ? LAST_IDX : CW'(bit_len);
    assign bidx     = BIDX_W'(bidx_ext);

    assign ram_re    = cmd.rec_rd || cmd.walk_rd;
    assign ram_raddr = cmd.rec_rd ? bidx : idx_reg;

    llhp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.rec_wr),
        .waddr (bidx_reg),
        .wdata (bucket_inc),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // A bucket not written since reset or the last clear reads as zero.
    assign bucket_val = rd_valid_reg ? ram_q : '0;
    assign bucket_inc = (bucket_val == {CNT_W{1'b1}}) ? bucket_val : bucket_val + 1'b1;

    // The target rank is never divided out. A running count reaches
    // ceil(count * ratio / 1e6) exactly when the count times one million reaches
    // count * ratio, so the walk keeps a scaled copy of its running count. A hit
    // also needs at least one sample, and reaching the full count always hits,
    // which covers the clamping of the target to 1..count.
    assign scaled_next = scaled_reg + SCL_W'(scl_inc_reg);
    assign hit         = (accum_reg != '0) &&
                         ((scaled_next >= SCL_W'(prod_reg)) ||
                          (accum_reg >= ACC_W'(total_reg)));
    assign idx_ext     = CW'(idx_reg);
    assign bound       = CNT_W'(1) << idx_ext;

    always_comb
    begin
        priority if (idx_reg == '0)
        begin
            hit_pct = '0;
        end
        else if (idx_ext >= CW'(CNT_W))
        begin
            hit_pct = max_reg;
        end
        else
        begin
            hit_pct = (bound < max_reg) ? bound : max_reg;
        end
    end

    assign status.empty     = (total_reg == '0);
    assign status.walk_hit  = hit;
    assign status.walk_last = (idx_reg == LAST_B);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
            max_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
            total_reg <= '0;
            max_reg   <= '0;
        end
        else if (cmd.rec_wr)
        begin
            valid_reg[bidx_reg] <= 1'b1;
            if (total_reg != {CNT_W{1'b1}})
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (sample_reg > max_reg)
            begin
                max_reg <= sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            rd_valid_reg <= valid_reg[ram_raddr];
        end
        if (cmd.accept)
        begin
            ratio_reg  <= req_data.ratio_ppm;
            sample_reg <= sample;
            bidx_reg   <= bidx;
        end
        if (cmd.q_mul)
        begin
            prod_reg   <= total_reg * ratio_reg;
            idx_reg    <= '0;
            accum_reg  <= '0;
            scaled_reg <= '0;
        end
        else if (cmd.walk_acc)
        begin
            accum_reg   <= accum_reg + ACC_W'(bucket_val);
            scl_inc_reg <= bucket_val * llhp_pkg::PPM_ONE;
        end
        else if (cmd.walk_cmp)
        begin
            scaled_reg <= scaled_next;
            if (!hit && !status.walk_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        priority if (cmd.accept)
        begin
            pct_reg <= '0;
        end
        else if (cmd.walk_cmp && hit)
        begin
            pct_reg <= hit_pct;
        end
        else if (cmd.walk_cmp && status.walk_last)
        begin
            pct_reg <= max_reg;
        end
        if (cmd.out_load)
        begin
            rsp_reg.percentile_us  <= pct_reg;
            rsp_reg.sample_count   <= total_reg;
            rsp_reg.max_latency_us <= max_reg;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

// ----- rtl/log2_latency_histogram_percentile.sv -----
// ----------------------------------------------------------------------------
// log2_latency_histogram_percentile
// Latency histogram with power-of-two buckets and percentile lookup.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req channel (req_valid, req_ready, req_data) and
// each gives exactly one item on the rsp channel (rsp_valid, rsp_ready,
// rsp_data), in order. A record item adds a sample, a query item returns the
// percentile bound, a clear item empties the histogram; code 3 changes nothing.
// The block works on one item at a time; req_ready is high only when idle.
// Steps per item, up to the one that loads the output register: a record
// reads its bucket and writes it back incremented (read-modify-write of the
// bucket RAM); clear and code 3 go straight to the output. A query on an
// empty histogram answers zero; otherwise it walks 1 to NUM_BUCKETS buckets,
// each with a RAM read, an accumulate and a compare. The result is valid at
// the end of the loading cycle, and the next item can be accepted in the one after.
// Reset empties the histogram at once through per-bucket valid bits; no
// clearing pass is needed. The result waits in an output register; a new
// item is accepted meanwhile, and its own result is held back until the
// receiver has taken the previous one.
// ----------------------------------------------------------------------------
module log2_latency_histogram_percentile #(
    parameter int NUM_BUCKETS  = 33,
    parameter int LATENCY_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  llhp_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output llhp_pkg::rsp_t rsp_data
);

    llhp_pkg::cmd_t    cmd;
    llhp_pkg::status_t status;

    llhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_data.req_type),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    llhp_dp #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .LATENCY_BITS (LATENCY_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_data (req_data),
        .status   (status),
        .rsp_data (rsp_data)
    );

endmodule

// ----- rtl/llhp_checker.sv -----
// ----------------------------------------------------------------------------
// llhp_checker
// Port-level checks of the latency histogram, bound to the top level.
// ----------------------------------------------------------------------------
`include "log2_latency_histogram_percentile_defines.svh"

module llhp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input llhp_pkg::req_t req_data,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input llhp_pkg::rsp_t rsp_data
);

    // A stalled result keeps its valid flag and its payload.
    `LLHP_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

    // Only one item is in flight, so an acceptance closes the input.
    `LLHP_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready, "second item accepted while busy")

    // A percentile is capped by the maximum sample.
    `LLHP_ASSERT_NOW(a_pct_le_max, clk, rst_n, rsp_valid, rsp_data.percentile_us <= rsp_data.max_latency_us, "percentile above maximum")

    // With no samples both the maximum and the percentile are zero.
    `LLHP_ASSERT_NOW(a_empty_zero, clk, rst_n, rsp_valid && (rsp_data.sample_count == '0), (rsp_data.max_latency_us == '0) && (rsp_data.percentile_us == '0), "non-zero result with no samples")

endmodule

bind log2_latency_histogram_percentile llhp_checker u_llhp_checker (.*);

// ----- bench/tb_log2_latency_histogram_percentile.sv -----
// ----------------------------------------------------------------------------
// tb_log2_latency_histogram_percentile
// Self-checking bench for the power-of-two latency histogram. A short table
// of directed items covers the empty histogram, the extreme samples and
// ratios, the ignored code and clearing. Random traffic follows, mostly
// records with queries mixed in, under three patterns of idling on the two
// channels. Results are checked against the table where it gives them, else
// against a mirror of the histogram, kept up to date as items are accepted.
// ----------------------------------------------------------------------------
module tb_log2_latency_histogram_percentile;

    localparam int          N_BUCKETS    = 33;
    localparam logic [1:0]  REQ_IGNORED  = 2'd3;
    localparam logic [63:0] PPM          = 64'd1000000;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          SETTLE       = 12;

    localparam logic [19:0] RATIO_EDGES [5] = '{20'd0, 20'd1, 20'd999999, 20'd1000000,
                                               20'hFFFFF};
    localparam logic [19:0] RATIO_USUAL [4] = '{20'd500000, 20'd900000, 20'd990000,
                                               20'd999000};

    typedef struct packed {
        logic [1:0]     code;
        logic [31:0]    lat;
        logic [19:0]    ratio;
        logic           known;
        llhp_pkg::rsp_t want;
    } dir_row_t;

    localparam int N_DIRECTED = 23;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{llhp_pkg::REQ_QUERY,  32'd0,         20'd500000,  1'b1, '{32'd0, 32'd0, 32'd0}},
        '{llhp_pkg::REQ_RECORD, 32'd0,         20'd0,       1'b1, '{32'd0, 32'd1, 32'd0}},
        '{llhp_pkg::REQ_QUERY,  32'd0,         20'd1000000, 1'b1, '{32'd0, 32'd1, 32'd0}},
        '{llhp_pkg::REQ_RECORD, 32'hFFFF_FFFF, 20'd0,       1'b1, '{32'd0, 32'd2, ALL_ONES}},
        '{llhp_pkg::REQ_QUERY,  32'd0,         20'd0,       1'b1, '{32'd0, 32'd2, ALL_ONES}},
        '{llhp_pkg::REQ_QUERY,  32'd0,         20'd1000000, 1'b1,
          '{ALL_ONES, 32'd2, ALL_ONES}},
        '{llhp_pkg::REQ_QUERY,  32'hFFFF_FFFF, 20'hFFFFF,   1'b1,
          '{ALL_ONES, 32'd2, ALL_ONES}},
        '{REQ_IGNORED,          32'd5,         20'd7,       1'b1, '{32'd0, 32'd2, ALL_ONES}},
        '{llhp_pkg::REQ_CLEAR,  32'hFFFF_FFFF, 20'hFFFFF,   1'b1, '{32'd0, 32'd0, 32'd0}},
        '{llhp_pkg::REQ_QUERY,  32'd0,         20'd1000000, 1'b1, '{32'd0, 32'd0, 32'd0}},
        '{llhp_pkg::REQ_RECORD, 32'd1,         20'd0,       1'b1, '{32'd0, 32'd1, 32'd1}},
        '{llhp_pkg::REQ_QUERY,  32'd0,         20'd500000,  1'b1, '{32'd1, 32'd1, 32'd1}},
        '{llhp_pkg::REQ_RECORD, 32'h8000_0000, 20'd0,       1'b1,
          '{32'd0, 32'd2, 32'h8000_0000}},
        '{llhp_pkg::REQ_RECORD, 32'd3,         20'd0,       1'b0, '0},
        '{llhp_pkg::REQ_RECORD, 32'h0001_0000, 20'd0,       1'b0, '0},
        '{llhp_pkg::REQ_QUERY,  32'd0,         20'd500000,  1'b0, '0},
        '{llhp_pkg::REQ_QUERY,  32'd0,         20'd750000,  1'b0, '0},
        '{llhp_pkg::REQ_QUERY,  32'd0,         20'd1,       1'b0, '0},
        '{llhp_pkg::REQ_RECORD, 32'h7FFF_FFFF, 20'd0,       1'b0, '0},
        '{llhp_pkg::REQ_QUERY,  32'd0,         20'd999999,  1'b0, '0},
        '{llhp_pkg::REQ_RECORD, 32'h5555_5555, 20'hFFFFF,   1'b0, '0},
        '{llhp_pkg::REQ_QUERY,  32'hAAAA_AAAA, 20'hAAAAA,   1'b0, '0},
        '{llhp_pkg::REQ_CLEAR,  32'd0,         20'd0,       1'b1, '{32'd0, 32'd0, 32'd0}}
    };

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    llhp_pkg::req_t req_data;
    logic           rsp_valid;
    logic           rsp_ready;
    llhp_pkg::rsp_t rsp_data;

    // Mirror of the histogram, updated whenever an item is accepted.
    logic [31:0]    hist_buckets [N_BUCKETS];
    logic [31:0]    hist_total;
    logic [31:0]    hist_peak;
    llhp_pkg::rsp_t awaited_results [$];

    int mismatches = 0;
    int checked    = 0;
    int cycles     = 0;
    int n_record   = 0;
    int n_query    = 0;
    int n_clear    = 0;
    int n_ignored  = 0;
    int send_gap;
    int recv_gap;

    log2_latency_histogram_percentile DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int bucket_index(logic [31:0] v);
        int len;
        len = 0;
        while (v != 0)
        begin
            len++;
            v = v >> 1;
        end
        return (len > N_BUCKETS - 1) ? N_BUCKETS - 1 : len;
    endfunction

    function automatic logic [31:0] percentile_of(logic [19:0] ratio);
        logic [63:0] target;
        logic [63:0] running;
        logic [63:0] bound;
        if (hist_total == 0)
            return '0;
        target = (64'(hist_total) * 64'(ratio) + PPM - 64'd1) / PPM;
        if (target == 0)
            target = 64'd1;
        if (target > 64'(hist_total))
            target = 64'(hist_total);
        running = '0;
        for (int i = 0; i < N_BUCKETS; i++)
        begin
            running += 64'(hist_buckets[i]);
            if (running >= target)
            begin
                if (i == 0)
                    return '0;
                bound = 64'd1 << i;
                return (bound < 64'(hist_peak)) ? bound[31:0] : hist_peak;
            end
        end
        return hist_peak;
    endfunction

    function automatic llhp_pkg::rsp_t predict_histogram(llhp_pkg::req_t r);
        llhp_pkg::rsp_t res;
        int             b;
        res.percentile_us = '0;
        case (r.req_type)
            llhp_pkg::REQ_RECORD:
            begin
                n_record++;
                b = bucket_index(r.latency_us);
                if (hist_buckets[b] != ALL_ONES)
                    hist_buckets[b] += 32'd1;
                if (hist_total != ALL_ONES)
                    hist_total += 32'd1;
                if (r.latency_us > hist_peak)
                    hist_peak = r.latency_us;
            end
            llhp_pkg::REQ_QUERY:
            begin
                n_query++;
                res.percentile_us = percentile_of(r.ratio_ppm);
            end
            llhp_pkg::REQ_CLEAR:
            begin
                n_clear++;
                for (int i = 0; i < N_BUCKETS; i++)
                    hist_buckets[i] = '0;
                hist_total = '0;
                hist_peak  = '0;
            end
            default:
                n_ignored++;
        endcase
        res.sample_count   = hist_total;
        res.max_latency_us = hist_peak;
        return res;
    endfunction

    function automatic llhp_pkg::req_t random_request();
        llhp_pkg::req_t r;
        int             pick;
        int             shift;
        pick = $urandom_range(0, 999);
        if (pick < 700)
            r.req_type = llhp_pkg::REQ_RECORD;
        else if (pick < 975)
            r.req_type = llhp_pkg::REQ_QUERY;
        else if (pick < 985)
            r.req_type = llhp_pkg::REQ_CLEAR;
        else
            r.req_type = REQ_IGNORED;
        // Spread samples evenly over the bit lengths so that every bucket fills.
        shift = $urandom_range(0, 32);
        r.latency_us = $urandom;
        r.latency_us = (shift == 32) ? 32'd0 : r.latency_us >> shift;
        if ($urandom_range(0, 19) == 0)
            r.latency_us = ALL_ONES;
        case ($urandom_range(0, 4))
            0, 4: r.ratio_ppm = 20'($urandom_range(0, 1000000));
            1:    r.ratio_ppm = RATIO_EDGES[$urandom_range(0, 4)];
            2:    r.ratio_ppm = 20'($urandom);
            default: r.ratio_ppm = RATIO_USUAL[$urandom_range(0, 3)];
        endcase
        return r;
    endfunction

    task automatic report(string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(llhp_pkg::req_t r, logic known, llhp_pkg::rsp_t want);
        llhp_pkg::rsp_t predicted;
        while ($urandom_range(0, 99) < send_gap)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = predict_histogram(r);
        awaited_results = {awaited_results, (known ? want : predicted)};
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= recv_gap);

    always @(posedge clk)
    begin
        llhp_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_results.size() == 0)
                report($sformatf("result %h with nothing outstanding", rsp_data));
            else
            begin
                want = awaited_results.pop_front();
                checked++;
                check_field("percentile_us", rsp_data.percentile_us, want.percentile_us);
                check_field("sample_count", rsp_data.sample_count, want.sample_count);
                check_field("max_latency_us", rsp_data.max_latency_us, want.max_latency_us);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("run stopped at the cycle limit, %0d results outstanding",
                     awaited_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        llhp_pkg::req_t r;
        int             sent;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        rsp_ready = 1'b0;
        send_gap  = 17;
        recv_gap  = 52;
        for (int i = 0; i < N_BUCKETS; i++)
            hist_buckets[i] = '0;
        hist_total = '0;
        hist_peak  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            r.req_type   = DIRECTED[i].code;
            r.latency_us = DIRECTED[i].lat;
            r.ratio_ppm  = DIRECTED[i].ratio;
            send_item(r, DIRECTED[i].known, DIRECTED[i].want);
        end
        // Hold the sender back until the block has drained completely.
        wait_for_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap = 17;
                    recv_gap = 52;
                end
                1:
                begin
                    send_gap = 52;
                    recv_gap = 17;
                end
                default:
                begin
                    send_gap = 0;
                    recv_gap = 0;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                r = random_request();
                send_item(r, 1'b0, '0);
                if (r.req_type != REQ_IGNORED)
                    sent++;
            end
            wait_for_results();
        end
        repeat (SETTLE) @(negedge clk);

        $display("covered %0d records, %0d queries, %0d clears and %0d ignored items",
                 n_record, n_query, n_clear, n_ignored);
        $display("%0d results checked in %0d cycles, %0d mismatches",
                 checked, cycles, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
